// ===== hw/rtl/ahrd_pkg.sv =====
// Shared types, constants and helpers for the ASCII hex record deframer.
`default_nettype none

package ahrd_pkg;

    localparam int RECORD_COUNT_BITS = 16;

    localparam int POS_W   = 32;
    localparam int LEN_W   = 32;
    localparam int VALUE_W = 38;
    localparam int NUM_W   = 16;
    localparam int NIB_W   = 8;
    localparam int LIMIT_W = 33;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] CHAR_FCODE = 8'h72;

    localparam logic [NIB_W-1:0] NIB_BAD = 8'hFF;
    localparam logic [NIB_W-1:0] NIB_ONE = 8'h01;

    localparam logic [POS_W-1:0] POS_HDR_LAST  = 32'd1;
    localparam logic [POS_W-1:0] POS_FCODE     = 32'd12;
    localparam logic [POS_W-1:0] POS_LEN_FIRST = 32'd13;
    localparam logic [POS_W-1:0] POS_LEN_LAST  = 32'd20;
    localparam logic [POS_W-1:0] POS_REC_FIRST = 32'd21;
    localparam logic [POS_W-1:0] POS_MAX       = '1;

    localparam logic [3:0] REC_DIGITS = 4'd8;

    localparam logic [LIMIT_W-1:0] LEN_OVERHEAD_M1 = 33'd26;
    localparam logic [LIMIT_W-1:0] RECORD_CHARS    = 33'd9;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX       = 33'd4294967283;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FUNC = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [NIB_W-1:0] nib;
        logic [2:0]       shift;
        logic             hdr_bad;
        logic             fcode_bad;
        logic             len_digit;
        logic             rec_sign;
        logic             rec_digit;
        logic             rec_done;
        logic             last;
        logic [POS_W-1:0] pos;
    } ahrd_op_t;

    function automatic logic [NIB_W-1:0] hex_nibble(input logic [7:0] c);
        logic [NIB_W-1:0] n;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                n = c - CHAR_ZERO;
            end
            else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
            begin
                n = c - CHAR_LOW_A + 8'd10;
            end
            else
            begin
                n = NIB_BAD;
            end
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ahrd_front.sv =====
// Front end: tracks frame position and turns each character into a request.
`default_nettype none

module ahrd_front
    import ahrd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] char_in,
    input  wire logic       frame_end,
    output ahrd_op_t        op
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [3:0]       rci_reg;
    logic [3:0]       rci_next;
    logic [3:0]       k;
    logic             in_rec;
    logic [POS_W-1:0] len_off;

    always_comb
    begin
        in_rec  = (pos_reg >= POS_REC_FIRST);
        k       = (rci_reg > REC_DIGITS) ? REC_DIGITS : rci_reg;
        len_off = pos_reg - POS_LEN_FIRST;

        op.nib       = hex_nibble(char_in);
        op.hdr_bad   = (pos_reg <= POS_HDR_LAST) && (char_in != CHAR_ZERO);
        op.fcode_bad = (pos_reg == POS_FCODE) && (char_in != CHAR_FCODE);
        op.len_digit = (pos_reg >= POS_LEN_FIRST) && (pos_reg <= POS_LEN_LAST);
        op.rec_sign  = in_rec && (rci_reg == 4'd0);
        op.rec_digit = in_rec && (rci_reg != 4'd0);
        op.rec_done  = op.rec_digit && (k >= REC_DIGITS);
        op.last      = frame_end;
        op.pos       = pos_reg;
        if (op.len_digit)
        begin
            op.shift = len_off[2:0];
        end
        else
        begin
            op.shift = 3'(k - 4'd1);
        end

        rci_next = rci_reg;
        if (op.rec_sign)
        begin
            rci_next = 4'd1;
        end
        else if (op.rec_done)
        begin
            rci_next = 4'd0;
        end
        else if (op.rec_digit)
        begin
            rci_next = k + 4'd1;
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 32'd1;
        if (frame_end)
        begin
            pos_next = '0;
            rci_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            rci_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
            rci_reg <= rci_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ahrd_queue.sv =====
// Two-entry queue of classified requests between the front and back ends.
`default_nettype none

module ahrd_queue
    import ahrd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ahrd_op_t push_op,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output ahrd_op_t      head
);

    ahrd_op_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full      = (count_reg == 2'd2);
        not_empty = (count_reg != 2'd0);
        head      = entry_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ahrd_back.sv =====
// Back end: decodes length and records, checks the frame and drives the output register.
`default_nettype none

module ahrd_back
    import ahrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 op_valid,
    input  wire ahrd_op_t             op,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      kind,
    output logic signed [VALUE_W-1:0] record_value,
    output logic [NUM_W-1:0]          record_number,
    output logic [1:0]                frame_status
);

    logic [1:0]                   err_reg;
    logic [1:0]                   err_next;
    logic [LEN_W-1:0]             len_reg;
    logic [LEN_W-1:0]             len_next;
    logic [VALUE_W-1:0]           acc_reg;
    logic [VALUE_W-1:0]           acc_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [RECORD_COUNT_BITS-1:0] done_reg;
    logic [RECORD_COUNT_BITS-1:0] done_next;
    logic [LIMIT_W-1:0]           limit_reg;
    logic [LIMIT_W-1:0]           limit_next;

    logic                         out_valid_reg;
    logic                         kind_reg;
    logic [VALUE_W-1:0]           value_reg;
    logic [NUM_W-1:0]             number_reg;
    logic [1:0]                   status_reg;

    logic                         can_load;
    logic                         emit_rec;
    logic                         produce;
    logic [LEN_W-1:0]             len_term;
    logic [VALUE_W-1:0]           acc_term;
    logic [1:0]                   status;
    logic [31:0]                  done_wide;
    logic [31:0]                  done_wide_next;

    always_comb
    begin
        can_load = !out_valid_reg || !out_stall;
        len_term = LEN_W'({24'd0, op.nib} << {op.shift, 2'b00});
        acc_term = VALUE_W'({30'd0, op.nib} << {op.shift, 2'b00});

        err_next = err_reg;
        if (op.hdr_bad && err_reg == STATUS_OK)
        begin
            err_next = STATUS_BAD_HDR;
        end
        if (op.fcode_bad && err_reg == STATUS_OK)
        begin
            err_next = STATUS_BAD_FUNC;
        end

        len_next = op.len_digit ? len_reg + len_term : len_reg;

        neg_next = neg_reg;
        acc_next = acc_reg;
        if (op.rec_sign)
        begin
            neg_next = (op.nib == NIB_ONE);
            acc_next = '0;
        end
        else if (op.rec_digit)
        begin
            acc_next = neg_reg ? acc_reg - acc_term : acc_reg + acc_term;
        end

        done_next  = done_reg;
        limit_next = limit_reg;
        if (op.rec_done)
        begin
            if (done_reg != '1)
            begin
                done_next = done_reg + RECORD_COUNT_BITS'(1);
            end
            if (limit_reg != LIMIT_MAX)
            begin
                limit_next = limit_reg + RECORD_CHARS;
            end
        end

        emit_rec = op.rec_done && !op.last && (err_next == STATUS_OK)
                   && (limit_reg <= {1'b0, len_reg});

        status = err_next;
        if (status == STATUS_OK && op.pos < POS_HDR_LAST)
        begin
            status = STATUS_BAD_HDR;
        end
        if (status == STATUS_OK && op.pos < POS_FCODE)
        begin
            status = STATUS_BAD_FUNC;
        end
        if (status == STATUS_OK
            && {1'b0, op.pos} != {1'b0, len_next} + LEN_OVERHEAD_M1)
        begin
            status = STATUS_BAD_LEN;
        end

        done_wide      = 32'(done_reg);
        done_wide_next = 32'(done_next);

        produce = op.last || emit_rec;
        pop     = op_valid && (!produce || can_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= STATUS_OK;
            len_reg       <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            done_reg      <= '0;
            limit_reg     <= RECORD_CHARS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                out_valid_reg <= pop && produce;
            end
            if (pop)
            begin
                if (op.last)
                begin
                    err_reg   <= STATUS_OK;
                    len_reg   <= '0;
                    acc_reg   <= '0;
                    neg_reg   <= 1'b0;
                    done_reg  <= '0;
                    limit_reg <= RECORD_CHARS;
                end
                else
                begin
                    err_reg   <= err_next;
                    len_reg   <= len_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    done_reg  <= done_next;
                    limit_reg <= limit_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            if (op.last)
            begin
                kind_reg   <= KIND_STATUS;
                value_reg  <= '0;
                number_reg <= done_wide_next[NUM_W-1:0];
                status_reg <= status;
            end
            else
            begin
                kind_reg   <= KIND_RECORD;
                value_reg  <= acc_next;
                number_reg <= done_wide[NUM_W-1:0];
                status_reg <= STATUS_OK;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign record_value  = value_reg;
    assign record_number = number_reg;
    assign frame_status  = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_hex_record_deframer.sv =====
// Top level of the ASCII hex record deframer.
//
// The input channel takes one frame character per request on char_in, with
// frame_end high on the frame's last character. The output channel gives one
// result per request: kind 0 is a decoded record (record_value in millionths,
// record_number its index in the frame), kind 1 is the end-of-frame status
// (frame_status, and record_number holding the count of complete records).
// Records from a frame whose status reports a length mismatch are to be
// discarded by the consumer.
// A character accepted at one clock edge is in the queue after that edge and
// its result, if any, is loaded into the output register when the back end
// takes it from the queue, which out_stall or earlier requests can delay.
// One character is accepted every cycle while in_stall is low; the front end,
// the two-entry queue and the back end each pass one request per cycle while
// out_stall is low. While out_stall is high the output register holds its
// result; the back end keeps consuming characters that produce no result, and
// once the queue is full in_stall rises until the result is taken.
// Reset clears the frame position, decoded length, error, record state and
// both handshakes; the block is ready for a new frame right after reset.
`default_nettype none

module ascii_hex_record_deframer
    import ahrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           char_in,
    input  wire logic                 frame_end,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      kind,
    output logic signed [VALUE_W-1:0] record_value,
    output logic [NUM_W-1:0]          record_number,
    output logic [1:0]                frame_status
);

    ahrd_op_t front_op;
    ahrd_op_t head_op;
    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    ahrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_in   (char_in),
        .frame_end (frame_end),
        .op        (front_op)
    );

    ahrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (front_op),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_op)
    );

    ahrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (q_not_empty),
        .op            (head_op),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .record_value  (record_value),
        .record_number (record_number),
        .frame_status  (frame_status)
    );

endmodule

`default_nettype wire
